>>> src/fvca_pkg.sv
// Shared types and constants for the flow-sticky VC allocator.
package fvca_pkg;

	// Opcode field values
	localparam logic [1:0] OP_ALLOC     = 2'd0;
	localparam logic [1:0] OP_WR_CREDIT = 2'd1;
	localparam logic [1:0] OP_WR_USAGE  = 2'd2;

	// Table entry widths and limits
	localparam int CREDIT_W = 6;
	localparam int USAGE_W  = 14;

	localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 6'd63;
	localparam logic [USAGE_W-1:0]  USAGE_MAX   = 14'd9999;
	localparam logic [USAGE_W-1:0]  USAGE_START = 14'd10000;

	// Allocation sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_UPDATE
	} state_t;

endpackage

>>> src/fvca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fvca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/flow_sticky_vc_allocator.sv
// Top level: per-packet output VC allocator with flow reuse and credit/usage tables.
//
// Input channel (in_valid / in_stall) carries one transaction per command: an
// allocate, a credit-table write or a usage-table write. Output channel
// (out_valid / out_stall) carries one result (chosen_vc, reused_flow) for each
// allocate on an existing port; writes and dropped commands give no result.
//
// Sequencing: a table write is taken in the idle state and the block stays ready
// for the next command. An allocate whose source/destination ids match the last
// scanned flow goes through fetch usage, write back and ready. A new flow first
// scans the port's NUM_VCS entries one per cycle through the single table read
// port, then fetches usage and writes back. The result enters the output
// register from the write-back step.
//
// Reset clears the sequencer, the output register, the last-flow record and the
// per-entry valid bits, so every table entry reads as zero until written. When
// the output register is full and out_stall is high, a finished allocate waits
// in its write-back step and in_stall stays high until the result can move.
module flow_sticky_vc_allocator #(
	parameter int NUM_PORTS = 8,
	parameter int NUM_VCS   = 4,
	parameter int ID_WIDTH  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [2:0]  out_port,
	input  logic [1:0]  vc_index,
	input  logic [13:0] write_value,
	input  logic [7:0]  src_id,
	input  logic [7:0]  dst_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  chosen_vc,
	output logic        reused_flow
);

	localparam int ENTRIES = NUM_PORTS * NUM_VCS;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int VC_W    = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
	localparam int ID_W    = (ID_WIDTH < 8) ? ID_WIDTH : 8;
	localparam logic [VC_W-1:0] VC_LAST = VC_W'(NUM_VCS - 1);

	// Flat table address of a port/VC pair
	function automatic logic [AW-1:0] entry_addr(input logic [2:0] port,
			input logic [VC_W-1:0] vc);
		logic [31:0] full;
		full = 32'(port) * 32'(NUM_VCS) + 32'(vc);
		return full[AW-1:0];
	endfunction

	fvca_pkg::state_t state_q, state_d;

	logic [VC_W-1:0]               cnt_q;
	logic [2:0]                    port_q;
	logic [ID_W-1:0]               src_q, dst_q;
	logic                          reused_q;
	logic [fvca_pkg::CREDIT_W-1:0] best_cred_q;
	logic [fvca_pkg::USAGE_W-1:0]  best_use_q;
	logic [VC_W-1:0]               best_vc_q;
	logic [VC_W-1:0]               vc_q;

	logic                          rd_vld_s1;
	logic [VC_W-1:0]               rd_vc_s1;
	logic                          rd_cvld_s1, rd_uvld_s1;

	logic                          last_valid_q;
	logic [ID_W-1:0]               last_src_q, last_dst_q;
	logic [VC_W-1:0]               last_vc_q;

	logic                          out_valid_q;
	logic [1:0]                    chosen_vc_q;
	logic                          reused_out_q;

	logic [ENTRIES-1:0]            credit_vld_q, usage_vld_q;

	logic                          in_acc, port_ok, vc_ok, hit, alloc_go;
	logic                          credit_we, usage_wr_in, usage_we, upd_fire;
	logic [AW-1:0]                 rd_addr, wr_addr_in, usage_waddr;
	logic [fvca_pkg::CREDIT_W-1:0] credit_rdata, credit_wdata, cur_cred;
	logic [fvca_pkg::USAGE_W-1:0]  usage_rdata, usage_wdata, cur_use;
	logic [fvca_pkg::USAGE_W-1:0]  usage_in_sat, usage_inc;
	logic                          take;
	logic [VC_W-1:0]               sel_vc;

	// Decode the incoming transaction
	assign in_acc     = in_valid && !in_stall;
	assign port_ok    = 32'(out_port) < 32'(NUM_PORTS);
	assign vc_ok      = 32'(vc_index) < 32'(NUM_VCS);
	assign hit        = last_valid_q && (last_src_q == src_id[ID_W-1:0])
		&& (last_dst_q == dst_id[ID_W-1:0]);
	assign alloc_go   = in_acc && (opcode == fvca_pkg::OP_ALLOC) && port_ok;
	assign wr_addr_in = entry_addr(out_port, VC_W'(vc_index));

	// Saturate write values
	assign credit_wdata = (write_value > 14'(fvca_pkg::CREDIT_MAX)) ?
		fvca_pkg::CREDIT_MAX : write_value[fvca_pkg::CREDIT_W-1:0];
	assign usage_in_sat = (write_value > fvca_pkg::USAGE_MAX) ?
		fvca_pkg::USAGE_MAX : write_value;

	// Unwritten entries read as zero
	assign cur_cred = rd_cvld_s1 ? credit_rdata : '0;
	assign cur_use  = rd_uvld_s1 ? usage_rdata : '0;

	// Compare the entry returned by the scan against the best so far
	assign take = rd_vld_s1 && ((cur_cred > best_cred_q)
		|| ((cur_cred == best_cred_q) && (cur_use < best_use_q)));
	assign sel_vc = reused_q ? last_vc_q : (take ? rd_vc_s1 : best_vc_q);

	// Increment usage with saturation
	assign usage_inc = (cur_use < fvca_pkg::USAGE_MAX) ?
		(cur_use + 14'd1) : fvca_pkg::USAGE_MAX;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fvca_pkg::ST_IDLE: begin
				if (alloc_go) begin
					state_d = hit ? fvca_pkg::ST_FETCH : fvca_pkg::ST_SCAN;
				end
			end
			fvca_pkg::ST_SCAN: begin
				if (cnt_q == VC_LAST) begin
					state_d = fvca_pkg::ST_FETCH;
				end
			end
			fvca_pkg::ST_FETCH: begin
				state_d = fvca_pkg::ST_UPDATE;
			end
			fvca_pkg::ST_UPDATE: begin
				if (!(out_valid_q && out_stall)) begin
					state_d = fvca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fvca_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs: stall, read address, table writes
	always_comb begin
		in_stall    = (state_q != fvca_pkg::ST_IDLE);
		upd_fire    = (state_q == fvca_pkg::ST_UPDATE) && !(out_valid_q && out_stall);
		credit_we   = in_acc && (opcode == fvca_pkg::OP_WR_CREDIT) && port_ok && vc_ok;
		usage_wr_in = in_acc && (opcode == fvca_pkg::OP_WR_USAGE) && port_ok && vc_ok;
		usage_we    = usage_wr_in || upd_fire;
		usage_waddr = upd_fire ? entry_addr(port_q, vc_q) : wr_addr_in;
		usage_wdata = upd_fire ? usage_inc : usage_in_sat;
		case (state_q)
			fvca_pkg::ST_SCAN:  rd_addr = entry_addr(port_q, cnt_q);
			fvca_pkg::ST_FETCH: rd_addr = entry_addr(port_q, sel_vc);
			default:            rd_addr = entry_addr(port_q, vc_q);
		endcase
	end

	// Table memories
	fvca_ram #(
		.WIDTH(fvca_pkg::CREDIT_W),
		.DEPTH(ENTRIES)
	) u_credit_ram (
		.clk  (clk),
		.we   (credit_we),
		.waddr(wr_addr_in),
		.wdata(credit_wdata),
		.raddr(rd_addr),
		.rdata(credit_rdata)
	);

	fvca_ram #(
		.WIDTH(fvca_pkg::USAGE_W),
		.DEPTH(ENTRIES)
	) u_usage_ram (
		.clk  (clk),
		.we   (usage_we),
		.waddr(usage_waddr),
		.wdata(usage_wdata),
		.raddr(rd_addr),
		.rdata(usage_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fvca_pkg::ST_IDLE;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			last_valid_q <= 1'b0;
			last_src_q   <= '0;
			last_dst_q   <= '0;
			last_vc_q    <= '0;
			out_valid_q  <= 1'b0;
			credit_vld_q <= '0;
			usage_vld_q  <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == fvca_pkg::ST_SCAN);
			// Advance the scan counter
			if (state_q == fvca_pkg::ST_SCAN) begin
				if (cnt_q != VC_LAST) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else begin
				cnt_q <= '0;
			end
			// Record a newly scanned flow
			if ((state_q == fvca_pkg::ST_FETCH) && !reused_q) begin
				last_valid_q <= 1'b1;
				last_src_q   <= src_q;
				last_dst_q   <= dst_q;
				last_vc_q    <= sel_vc;
			end
			// Output register
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// Mark written entries
			if (credit_we) begin
				credit_vld_q[wr_addr_in] <= 1'b1;
			end
			if (usage_we) begin
				usage_vld_q[usage_waddr] <= 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		rd_vc_s1   <= cnt_q;
		rd_cvld_s1 <= credit_vld_q[rd_addr];
		rd_uvld_s1 <= usage_vld_q[rd_addr];
		if (take) begin
			best_cred_q <= cur_cred;
			best_use_q  <= cur_use;
			best_vc_q   <= rd_vc_s1;
		end
		if (alloc_go) begin
			port_q      <= out_port;
			src_q       <= src_id[ID_W-1:0];
			dst_q       <= dst_id[ID_W-1:0];
			reused_q    <= hit;
			best_cred_q <= '0;
			best_use_q  <= fvca_pkg::USAGE_START;
			best_vc_q   <= '0;
		end
		if (state_q == fvca_pkg::ST_FETCH) begin
			vc_q <= sel_vc;
		end
		if (upd_fire) begin
			chosen_vc_q  <= 2'(vc_q);
			reused_out_q <= reused_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_vc   = chosen_vc_q;
	assign reused_flow = reused_out_q;

	// A result enters the output register only from the write-back step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fvca_pkg::ST_UPDATE))
		else $error("result appeared outside write-back");

	// Hold the write-back while the output register is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fvca_pkg::ST_UPDATE && out_valid_q && out_stall)
		|=> (state_q == fvca_pkg::ST_UPDATE))
		else $error("write-back left while output blocked");

	// A reused result needs a recorded flow
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && reused_out_q) |-> last_valid_q)
		else $error("reuse reported without recorded flow");

	// Scan counter stays within the VC range
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < 32'(NUM_VCS))
		else $error("scan counter out of range");

	// Usage writes stay within the saturation limit
	assert property (@(posedge clk) disable iff (!arst_n)
		usage_we |-> (usage_wdata <= fvca_pkg::USAGE_MAX))
		else $error("usage write above limit");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the flow-sticky VC allocator: directed and random commands.
module tb_top;

	localparam int NUM_PORTS = 8;
	localparam int NUM_VCS   = 4;
	localparam int ID_WIDTH  = 8;

	// Opcode value the block drops without a result
	localparam logic [1:0] OP_NOP = 2'd3;

	typedef struct packed {
		logic [1:0] vc;
		logic       reused;
	} vc_grant_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [2:0]  out_port;
	logic [1:0]  vc_index;
	logic [13:0] write_value;
	logic [7:0]  src_id;
	logic [7:0]  dst_id;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  chosen_vc;
	logic        reused_flow;

	// Shadow copy of the allocator state
	logic [fvca_pkg::CREDIT_W-1:0] credit_tbl [NUM_PORTS][NUM_VCS];
	logic [fvca_pkg::USAGE_W-1:0]  usage_tbl  [NUM_PORTS][NUM_VCS];
	bit                            flow_known;
	logic [7:0]                    flow_src;
	logic [7:0]                    flow_dst;
	logic [1:0]                    flow_vc;

	vc_grant_t pending_grants[$];

	int error_count;
	int alloc_count;
	int reuse_count;
	int write_count;
	int nop_count;
	int grant_count;
	bit idle_gaps;
	bit idle_stalls;
	int stall_left;

	flow_sticky_vc_allocator #(
		.NUM_PORTS(NUM_PORTS),
		.NUM_VCS  (NUM_VCS),
		.ID_WIDTH (ID_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.out_port   (out_port),
		.vc_index   (vc_index),
		.write_value(write_value),
		.src_id     (src_id),
		.dst_id     (dst_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chosen_vc  (chosen_vc),
		.reused_flow(reused_flow)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Pick an idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Apply one accepted command to the shadow state, queue the grant it yields
	function automatic void predict_grant(input logic [1:0] op, input logic [2:0] port,
			input logic [1:0] vci, input logic [13:0] val,
			input logic [7:0] src, input logic [7:0] dst);
		vc_grant_t                     g;
		logic [1:0]                    vc;
		logic [fvca_pkg::CREDIT_W-1:0] best_cred;
		logic [fvca_pkg::USAGE_W-1:0]  best_use;
		bit                            reuse;
		case (op)
		fvca_pkg::OP_WR_CREDIT: begin
			credit_tbl[port][vci] = (val > fvca_pkg::CREDIT_MAX) ?
				fvca_pkg::CREDIT_MAX : val[fvca_pkg::CREDIT_W-1:0];
			write_count++;
		end
		fvca_pkg::OP_WR_USAGE: begin
			usage_tbl[port][vci] = (val > fvca_pkg::USAGE_MAX) ? fvca_pkg::USAGE_MAX : val;
			write_count++;
		end
		fvca_pkg::OP_ALLOC: begin
			reuse = flow_known && flow_src == src && flow_dst == dst;
			if (reuse) begin
				vc = flow_vc;
				reuse_count++;
			end else begin
				// Scan for most credits, ties go to least usage, then lowest VC
				vc = '0;
				best_cred = '0;
				best_use = fvca_pkg::USAGE_START;
				for (int i = 0; i < NUM_VCS; i++) begin
					if (credit_tbl[port][i] > best_cred ||
							(credit_tbl[port][i] == best_cred && usage_tbl[port][i] < best_use)) begin
						vc = i[1:0];
						best_cred = credit_tbl[port][i];
						best_use = usage_tbl[port][i];
					end
				end
				flow_known = 1'b1;
				flow_src = src;
				flow_dst = dst;
				flow_vc = vc;
			end
			if (usage_tbl[port][vc] < fvca_pkg::USAGE_MAX)
				usage_tbl[port][vc] = usage_tbl[port][vc] + 1'b1;
			g.vc = vc;
			g.reused = reuse;
			pending_grants = {pending_grants, g};
			alloc_count++;
		end
		default: begin
			nop_count++;
		end
		endcase
	endfunction

	// Drive one command after an optional gap and hold it until taken
	task automatic send_cmd(input logic [1:0] op, input logic [2:0] port,
			input logic [1:0] vci, input logic [13:0] val,
			input logic [7:0] src, input logic [7:0] dst);
		int gap;
		gap = idle_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		opcode = op;
		out_port = port;
		vc_index = vci;
		write_value = val;
		src_id = src;
		dst_id = dst;
		do
			@(posedge clk);
		while (in_stall);
		predict_grant(op, port, vci, val, src, dst);
	endtask

	// Stall the result side at random
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall = 1'b1;
		end else if (idle_stalls && $urandom_range(0, 99) < 25) begin
			stall_left = pick_gap();
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// Compare each result transaction with the oldest expected grant
	always @(posedge clk) begin
		vc_grant_t g;
		if (arst_n && out_valid && !out_stall) begin
			grant_count++;
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result vc=%0d reused=%0d", $time,
					chosen_vc, reused_flow);
				error_count++;
			end else begin
				g = pending_grants.pop_front();
				if (chosen_vc !== g.vc) begin
					$display("%0t: chosen_vc expected %0d actual %0d", $time, g.vc, chosen_vc);
					error_count++;
				end
				if (reused_flow !== g.reused) begin
					$display("%0t: reused_flow expected %0d actual %0d", $time,
						g.reused, reused_flow);
					error_count++;
				end
			end
		end
	end

	// First allocations after reset: no flow recorded, then a match on another port
	task automatic test_reset_pick();
		send_cmd(fvca_pkg::OP_ALLOC, 3'd0, 2'd0, 14'd0, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd7, 2'd3, 14'h3fff, 8'd0, 8'd0);
	endtask

	// Saturating writes and ties on credit broken by usage
	task automatic test_write_saturation();
		send_cmd(fvca_pkg::OP_WR_CREDIT, 3'd7, 2'd3, 14'h3fff, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_WR_CREDIT, 3'd7, 2'd2, 14'd64, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd7, 2'd0, 14'd0, 8'd255, 8'd255);
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd7, 2'd2, 14'h3fff, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd7, 2'd3, 14'd10000, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd7, 2'd1, 14'd0, 8'd255, 8'd0);
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd7, 2'd3, 14'd9998, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd7, 2'd0, 14'd0, 8'd0, 8'd255);
	endtask

	// All credits zero: least usage wins, then flow reuse and a credit pulling the pick
	task automatic test_zero_credit();
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd3, 2'd0, 14'd5, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd3, 2'd1, 14'd2, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd3, 2'd2, 14'd2, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd3, 2'd3, 14'd9999, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd3, 2'd0, 14'd0, 8'd1, 8'd2);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd3, 2'd0, 14'd0, 8'd1, 8'd2);
		send_cmd(fvca_pkg::OP_WR_CREDIT, 3'd3, 2'd3, 14'd1, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd3, 2'd0, 14'd0, 8'd2, 8'd1);
	endtask

	// Unknown opcode leaves state alone; zero writes clear an entry
	task automatic test_unknown_opcode();
		send_cmd(OP_NOP, 3'd5, 2'd1, 14'h3fff, 8'd255, 8'd255);
		send_cmd(OP_NOP, 3'd0, 2'd0, 14'd0, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_ALLOC, 3'd3, 2'd2, 14'd0, 8'd2, 8'd1);
		send_cmd(fvca_pkg::OP_WR_CREDIT, 3'd0, 2'd0, 14'd0, 8'd0, 8'd0);
		send_cmd(fvca_pkg::OP_WR_USAGE, 3'd0, 2'd0, 14'd0, 8'd0, 8'd0);
	endtask

	// Random mix: table writes with small values for ties, allocations over a few flows
	task automatic test_random_mix(input int n);
		logic [7:0]  pool_src [6];
		logic [7:0]  pool_dst [6];
		logic [7:0]  prev_src;
		logic [7:0]  prev_dst;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [13:0] val;
		logic [1:0]  op;
		int          sent;
		int          r;
		int          k;
		for (int i = 0; i < 6; i++) begin
			pool_src[i] = 8'($urandom_range(0, 255));
			pool_dst[i] = 8'($urandom_range(0, 255));
		end
		prev_src = pool_src[0];
		prev_dst = pool_dst[0];
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			src = 8'($urandom_range(0, 255));
			dst = 8'($urandom_range(0, 255));
			val = 14'($urandom_range(0, 16383));
			if (r < 45) begin
				op = fvca_pkg::OP_ALLOC;
				r = $urandom_range(0, 99);
				if (r < 35) begin
					src = prev_src;
					dst = prev_dst;
				end else if (r < 75) begin
					k = $urandom_range(0, 5);
					src = pool_src[k];
					dst = pool_dst[k];
				end
				prev_src = src;
				prev_dst = dst;
			end else if (r < 70) begin
				op = fvca_pkg::OP_WR_CREDIT;
				r = $urandom_range(0, 99);
				if (r < 70)
					val = 14'($urandom_range(0, 6));
				else if (r < 90)
					val = 14'($urandom_range(0, 63));
			end else if (r < 92) begin
				op = fvca_pkg::OP_WR_USAGE;
				r = $urandom_range(0, 99);
				if (r < 50)
					val = 14'($urandom_range(0, 5));
				else if (r < 75)
					val = 14'($urandom_range(9990, 9999));
			end else begin
				op = OP_NOP;
			end
			send_cmd(op, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), val, src, dst);
			sent++;
		end
	endtask

	// Hard stop if the block hangs
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = fvca_pkg::OP_ALLOC;
		out_port = '0;
		vc_index = '0;
		write_value = '0;
		src_id = '0;
		dst_id = '0;
		idle_gaps = 1'b0;
		idle_stalls = 1'b0;
		stall_left = 0;
		error_count = 0;
		alloc_count = 0;
		reuse_count = 0;
		write_count = 0;
		nop_count = 0;
		grant_count = 0;
		flow_known = 1'b0;
		flow_src = '0;
		flow_dst = '0;
		flow_vc = '0;
		for (int p = 0; p < NUM_PORTS; p++)
			for (int v = 0; v < NUM_VCS; v++) begin
				credit_tbl[p][v] = '0;
				usage_tbl[p][v] = '0;
			end

		// Hold reset, then release it
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_reset_pick();
		test_write_saturation();
		test_zero_credit();
		test_unknown_opcode();

		// Back-to-back traffic, then traffic with gaps and stalls on both sides
		test_random_mix(300);
		idle_gaps = 1'b1;
		idle_stalls = 1'b1;
		test_random_mix(350);

		// Drain outstanding grants
		@(negedge clk);
		in_valid = 1'b0;
		idle_stalls = 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d allocations (%0d flow reuses), %0d table writes, %0d dropped",
			alloc_count, reuse_count, write_count, nop_count);
		$display("Checked %0d result transactions, %0d mismatches", grant_count, error_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
